// ===== rtl/fat12ccw_pkg.sv =====
package fat12ccw_pkg;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_WALK  = 1'b1;

  localparam logic [11:0] END_MARK = 12'hFFF;

  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_ABORT  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD0,
    ST_RD1,
    ST_OUT
  } walk_state_t;

  typedef struct packed {
    logic start;
    logic write;
    logic eval;
    logic rd_next;
    logic load_abort;
    logic load_final;
    logic load_full;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_cmd;
    logic head_end;
    logic at_limit;
    logic final_hit;
    logic last;
  } dp_sts_t;

endpackage

// ===== rtl/fat12ccw_in_if.sv =====
interface fat12ccw_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [12:0] fat_index;
  logic [7:0]  fat_byte;
  logic [11:0] first_cluster;
  logic [15:0] file_size;
  logic [31:0] dest_base;

  modport source (
    output valid, command, fat_index, fat_byte, first_cluster, file_size, dest_base,
    input  ready
  );

  modport sink (
    input  valid, command, fat_index, fat_byte, first_cluster, file_size, dest_base,
    output ready
  );
endinterface

// ===== rtl/fat12ccw_out_if.sv =====
interface fat12ccw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [9:0]  byte_count;
  logic [11:0] cluster;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, source_address, dest_address, byte_count, cluster, status, last,
    input  ready
  );

  modport sink (
    input  valid, source_address, dest_address, byte_count, cluster, status, last,
    output ready
  );
endinterface

// ===== rtl/fat12_cluster_chain_walker_core.sv =====
// FAT12 cluster chain walker.
// The input channel carries two kinds of item. A write item stores one byte of
// the FAT table and gives no result and leaves the block idle. A walk item
// gives a first cluster, a file size and a destination base, and the block then
// emits one copy descriptor per cluster on the result channel, the final one
// with last set. An empty chain or an overlong chain ends in one flagged result.
// The configuration port sets the data area base. The user must write it only
// while idle; the block itself does not enforce this. A full-cluster descriptor
// passes through the EVAL, RD0 and RD1 states, the final one that the file size
// calls for through EVAL and RD0, and an abort through EVAL alone; an empty chain
// gives its result in the cycle after the item is taken. RD0 and RD1 serve the
// two sequential byte reads per FAT entry through the single read port of the
// table memory. A walk occupies the block until its last result has been taken;
// the input side is not ready meanwhile. When the receiver stalls, the result is
// held in the output register and the walk pauses until it is taken. Reset returns
// the controller to idle and clears the data area base; the FAT table contents are
// not cleared and must be written before use.
module fat12_cluster_chain_walker_core
  import fat12ccw_pkg::*;
#(
  parameter int CLUSTER_BYTES = 512,
  parameter int MAX_CHAIN     = 64,
  parameter int FAT_BYTES     = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  fat12ccw_in_if.sink    in_ch,
  fat12ccw_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  fat12ccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fat12ccw_dp #(
    .CLUSTER_BYTES (CLUSTER_BYTES),
    .MAX_CHAIN     (MAX_CHAIN),
    .FAT_BYTES     (FAT_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .command        (in_ch.command),
    .fat_index      (in_ch.fat_index),
    .fat_byte       (in_ch.fat_byte),
    .first_cluster  (in_ch.first_cluster),
    .file_size      (in_ch.file_size),
    .dest_base      (in_ch.dest_base),
    .source_address (out_ch.source_address),
    .dest_address   (out_ch.dest_address),
    .byte_count     (out_ch.byte_count),
    .cluster        (out_ch.cluster),
    .status         (out_ch.status),
    .last           (out_ch.last)
  );

endmodule

// ===== rtl/fat12ccw_ram.sv =====
module fat12ccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fat12ccw_ctrl.sv =====
module fat12ccw_ctrl
  import fat12ccw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  walk_state_t state_r;
  walk_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.walk_cmd) begin
          state_nxt = sts.head_end ? ST_OUT : ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = sts.at_limit ? ST_OUT : ST_RD0;
      end
      ST_RD0: begin
        state_nxt = sts.final_hit ? ST_OUT : ST_RD1;
      end
      ST_RD1: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = sts.last ? ST_IDLE : ST_EVAL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid && sts.walk_cmd;
        cmd.write = in_valid && !sts.walk_cmd;
      end
      ST_EVAL: begin
        cmd.eval       = !sts.at_limit;
        cmd.load_abort = sts.at_limit;
      end
      ST_RD0: begin
        cmd.load_final = sts.final_hit;
        cmd.rd_next    = !sts.final_hit;
      end
      ST_RD1: begin
        cmd.load_full = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result sides active together");

  a_full_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_full |=> out_valid)
    else $error("descriptor loaded but not presented");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sts.last) |=> in_ready)
    else $error("walk finished but block not ready for the next item");

endmodule

// ===== rtl/fat12ccw_dp.sv =====
module fat12ccw_dp
  import fat12ccw_pkg::*;
#(
  parameter int CLUSTER_BYTES = 512,
  parameter int MAX_CHAIN     = 64,
  parameter int FAT_BYTES     = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_sts_t     sts,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        command,
  input  logic [12:0] fat_index,
  input  logic [7:0]  fat_byte,
  input  logic [11:0] first_cluster,
  input  logic [15:0] file_size,
  input  logic [31:0] dest_base,
  output logic [31:0] source_address,
  output logic [31:0] dest_address,
  output logic [9:0]  byte_count,
  output logic [11:0] cluster,
  output logic [1:0]  status,
  output logic        last
);

  localparam int          AW      = $clog2(FAT_BYTES);
  localparam logic [31:0] CB32    = 32'(CLUSTER_BYTES);
  localparam logic [31:0] TWO_CB  = 32'(2 * CLUSTER_BYTES);
  localparam logic [16:0] CB17    = 17'(CLUSTER_BYTES);
  localparam logic [13:0] FAT_LIM = 14'(FAT_BYTES);
  localparam logic [6:0]  MAX_CNT = 7'(MAX_CHAIN);

  logic [31:0] data_base_r;
  logic [11:0] cur_c_r;
  logic [15:0] rem_r;
  logic [31:0] dst_r;
  logic [6:0]  cnt_r;
  logic [31:0] prod_r;
  logic [13:0] pos_r;
  logic        ok_r;
  logic [7:0]  b0_r;

  logic [31:0] src_r;
  logic [31:0] dsto_r;
  logic [9:0]  bcnt_r;
  logic [11:0] clo_r;
  logic [1:0]  stat_r;
  logic        last_r;

  logic [13:0] c3;
  logic [13:0] pos_head;
  logic [13:0] rd_pos;
  logic        rd_en;
  logic [7:0]  rdata;
  logic [7:0]  b1;
  logic [11:0] nxt_entry;
  logic [31:0] src_calc;
  logic [15:0] rem_step;
  logic        wr_en;

  assign c3       = {2'b00, cur_c_r} + {1'b0, cur_c_r, 1'b0};
  assign pos_head = {1'b0, c3[13:1]};
  assign rd_pos   = cmd.eval ? pos_head : pos_r + 14'd1;
  assign rd_en    = cmd.eval || cmd.rd_next || cmd.load_full;
  assign b1       = ok_r ? rdata : 8'd0;
  assign nxt_entry = cur_c_r[0] ? {b1, b0_r[7:4]} : {b1[3:0], b0_r};
  assign src_calc = data_base_r + prod_r - TWO_CB;
  assign rem_step = ({1'b0, rem_r} > CB17) ? 16'({1'b0, rem_r} - CB17) : rem_r;
  assign wr_en    = cmd.write && ({1'b0, fat_index} < FAT_LIM);

  assign sts.walk_cmd  = (command == CMD_WALK);
  assign sts.head_end  = (first_cluster == END_MARK);
  assign sts.at_limit  = (cnt_r >= MAX_CNT);
  assign sts.final_hit = (rem_r != 16'd0) && ({1'b0, rem_r} <= CB17);
  assign sts.last      = last_r;

  fat12ccw_ram #(
    .WIDTH (8),
    .DEPTH (FAT_BYTES)
  ) u_fat_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fat_index[AW-1:0]),
    .wdata (fat_byte),
    .re    (rd_en),
    .raddr (rd_pos[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= '0;
    end else if (cfg_we) begin
      data_base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_c_r <= first_cluster;
      rem_r   <= file_size;
      dst_r   <= dest_base;
      cnt_r   <= 7'd1;
      if (first_cluster == END_MARK) begin
        src_r  <= '0;
        dsto_r <= dest_base;
        bcnt_r <= '0;
        clo_r  <= END_MARK;
        stat_r <= STATUS_EMPTY;
        last_r <= 1'b1;
      end
    end
    if (cmd.eval) begin
      prod_r <= 32'(cur_c_r) * CB32;
    end
    if (rd_en) begin
      pos_r <= rd_pos;
      ok_r  <= (rd_pos < FAT_LIM);
    end
    if (cmd.rd_next) begin
      b0_r <= ok_r ? rdata : 8'd0;
    end
    if (cmd.load_abort) begin
      src_r  <= '0;
      dsto_r <= dst_r;
      bcnt_r <= '0;
      clo_r  <= cur_c_r;
      stat_r <= STATUS_ABORT;
      last_r <= 1'b1;
    end
    if (cmd.load_final) begin
      src_r  <= src_calc;
      dsto_r <= dst_r;
      bcnt_r <= rem_r[9:0];
      clo_r  <= cur_c_r;
      stat_r <= STATUS_NORMAL;
      last_r <= 1'b1;
    end
    if (cmd.load_full) begin
      src_r   <= src_calc;
      dsto_r  <= dst_r;
      bcnt_r  <= CB32[9:0];
      clo_r   <= cur_c_r;
      stat_r  <= STATUS_NORMAL;
      last_r  <= (nxt_entry == END_MARK);
      cur_c_r <= nxt_entry;
      dst_r   <= dst_r + CB32;
      cnt_r   <= cnt_r + 7'd1;
      rem_r   <= rem_step;
    end
  end

  assign source_address = src_r;
  assign dest_address   = dsto_r;
  assign byte_count     = bcnt_r;
  assign cluster        = clo_r;
  assign status         = stat_r;
  assign last           = last_r;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import fat12ccw_pkg::*;

  localparam int CLUSTER_BYTES = 512;
  localparam int MAX_CHAIN     = 64;
  localparam int FAT_BYTES     = 8192;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic        command;
    logic [12:0] fat_index;
    logic [7:0]  fat_byte;
    logic [11:0] first_cluster;
    logic [15:0] file_size;
    logic [31:0] dest_base;
  } fat_cmd_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [9:0]  byte_count;
    logic [11:0] cluster;
    logic [1:0]  status;
    logic        last;
  } descriptor_t;

  typedef struct packed {
    fat_cmd_t    item;
    logic        fixed;
    descriptor_t want;
  } row_t;

  localparam descriptor_t NO_WANT = '0;

  localparam row_t DIRECTED [25] = '{
    '{'{CMD_WALK, 13'd0, 8'd0, END_MARK, 16'd0, 32'hFFFF_FFFF}, 1'b1,
      '{32'd0, 32'hFFFF_FFFF, 10'd0, END_MARK, STATUS_EMPTY, 1'b1}},
    '{'{CMD_WALK, 13'd0, 8'd0, END_MARK, 16'd32768, 32'd0}, 1'b1,
      '{32'd0, 32'd0, 10'd0, END_MARK, STATUS_EMPTY, 1'b1}},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd2, 16'd1, 32'd0}, 1'b1,
      '{32'd0, 32'd0, 10'd1, 12'd2, STATUS_NORMAL, 1'b1}},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd0, 16'd512, 32'h0000_1000}, 1'b1,
      '{32'hFFFF_FC00, 32'h0000_1000, 10'd512, 12'd0, STATUS_NORMAL, 1'b1}},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'hFFE, 16'd511, 32'd0}, 1'b1,
      '{32'h001F_F800, 32'd0, 10'd511, 12'hFFE, STATUS_NORMAL, 1'b1}},
    '{'{CMD_WRITE, 13'd3, 8'h03, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd4, 8'hF0, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd5, 8'hFF, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd2, 16'd0, 32'h0000_0100}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd2, 16'd700, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd3, 16'd0, 32'h8000_0000}, 1'b1,
      '{32'h0000_0200, 32'h8000_0000, 10'd512, 12'd3, STATUS_NORMAL, 1'b1}},
    '{'{CMD_WRITE, 13'd0, 8'hFF, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd1, 8'hFF, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd2, 8'hFF, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd0, 16'd0, 32'd0}, 1'b1,
      '{32'hFFFF_FC00, 32'd0, 10'd512, 12'd0, STATUS_NORMAL, 1'b1}},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd1, 16'd0, 32'd0}, 1'b1,
      '{32'hFFFF_FE00, 32'd0, 10'd512, 12'd1, STATUS_NORMAL, 1'b1}},
    '{'{CMD_WRITE, 13'd15, 8'h0A, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd16, 8'h00, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd10, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd10, 16'd32768, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'd10, 16'd1536, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd8191, 8'hFF, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd6141, 8'hFF, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WRITE, 13'd6142, 8'h0F, 12'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
    '{'{CMD_WALK, 13'd0, 8'd0, 12'hFFE, 16'd0, 32'd0}, 1'b1,
      '{32'h001F_F800, 32'd0, 10'd512, 12'hFFE, STATUS_NORMAL, 1'b1}}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  fat12ccw_in_if  in_if();
  fat12ccw_out_if out_if();

  fat12_cluster_chain_walker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  logic [7:0]  fat_mem [FAT_BYTES];
  bit          fat_known [FAT_BYTES];
  logic [31:0] data_base_now;
  descriptor_t descriptors_due [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  mismatches;
  int  cycle_count;
  int  items_sent;
  int  walks_sent;
  int  writes_sent;
  int  descriptors_seen;
  int  aborts_seen;
  int  empties_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic descriptor_t make_desc(input logic [31:0] src, input logic [31:0] dst,
                                            input logic [9:0] count, input logic [11:0] cl,
                                            input logic [1:0] st, input logic fin);
    descriptor_t d;
    d.source_address = src;
    d.dest_address   = dst;
    d.byte_count     = count;
    d.cluster        = cl;
    d.status         = st;
    d.last           = fin;
    return d;
  endfunction

  function automatic logic [11:0] fat_entry(input logic [11:0] c);
    int         p;
    logic [7:0] b0;
    logic [7:0] b1;
    p = int'(c) * 3 / 2;
    b0 = fat_mem[p];
    b1 = fat_mem[p + 1];
    return c[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
  endfunction

  function automatic int cluster_limit(input logic [15:0] size);
    return int'(size) / CLUSTER_BYTES + ((int'(size) % CLUSTER_BYTES) != 0 ? 1 : 0);
  endfunction

  task automatic predict_descriptors(input fat_cmd_t item);
    logic [31:0] dst;
    logic [31:0] src;
    logic [11:0] c;
    logic [11:0] nxt;
    logic [9:0]  final_count;
    int          lim;
    int          n;
    if (item.command == CMD_WRITE) begin
      fat_mem[item.fat_index]   = item.fat_byte;
      fat_known[item.fat_index] = 1'b1;
      return;
    end
    dst = item.dest_base;
    if (item.first_cluster == END_MARK) begin
      descriptors_due.push_back(make_desc(32'd0, dst, 10'd0, END_MARK, STATUS_EMPTY, 1'b1));
      return;
    end
    lim = cluster_limit(item.file_size);
    final_count = (int'(item.file_size) % CLUSTER_BYTES != 0) ?
                  10'(int'(item.file_size) % CLUSTER_BYTES) : 10'(CLUSTER_BYTES);
    c = item.first_cluster;
    for (n = 1; n <= MAX_CHAIN; n++) begin
      if (n >= MAX_CHAIN) begin
        descriptors_due.push_back(make_desc(32'd0, dst, 10'd0, c, STATUS_ABORT, 1'b1));
        break;
      end
      src = data_base_now + (32'(c) - 32'd2) * 32'(CLUSTER_BYTES);
      if (n == lim) begin
        descriptors_due.push_back(make_desc(src, dst, final_count, c, STATUS_NORMAL, 1'b1));
        break;
      end
      nxt = fat_entry(c);
      descriptors_due.push_back(make_desc(src, dst, 10'(CLUSTER_BYTES), c, STATUS_NORMAL,
                                          nxt == END_MARK));
      if (nxt == END_MARK) break;
      c = nxt;
      dst = dst + 32'(CLUSTER_BYTES);
    end
  endtask

  task automatic send_cmd(input fat_cmd_t item, input logic fixed, input descriptor_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.command       = item.command;
    in_if.fat_index     = item.fat_index;
    in_if.fat_byte      = item.fat_byte;
    in_if.first_cluster = item.first_cluster;
    in_if.file_size     = item.file_size;
    in_if.dest_base     = item.dest_base;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (fixed) descriptors_due.push_back(want);
    else predict_descriptors(item);
    if (item.command == CMD_WALK) walks_sent++;
    else writes_sent++;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_write(input int idx, input logic [7:0] value);
    fat_cmd_t item;
    item.command       = CMD_WRITE;
    item.fat_index     = 13'(idx);
    item.fat_byte      = value;
    item.first_cluster = 12'($urandom);
    item.file_size     = 16'($urandom_range(0, 32768));
    item.dest_base     = $urandom;
    send_cmd(item, 1'b0, NO_WANT);
  endtask

  task automatic send_walk(input logic [11:0] head, input logic [15:0] size,
                           input logic [31:0] dst);
    fat_cmd_t item;
    item.command       = CMD_WALK;
    item.fat_index     = 13'($urandom);
    item.fat_byte      = 8'($urandom);
    item.first_cluster = head;
    item.file_size     = size;
    item.dest_base     = dst;
    send_cmd(item, 1'b0, NO_WANT);
  endtask

  // Bytes not yet written take random values, so every nibble the block reads is defined.
  task automatic set_entry(input logic [11:0] c, input logic [11:0] v, input bit only_unknown);
    int         p;
    logic [7:0] b0;
    logic [7:0] b1;
    p = int'(c) * 3 / 2;
    b0 = fat_known[p] ? fat_mem[p] : 8'($urandom);
    b1 = fat_known[p + 1] ? fat_mem[p + 1] : 8'($urandom);
    if (c[0]) begin
      b0[7:4] = v[3:0];
      b1      = v[11:4];
    end else begin
      b0      = v[7:0];
      b1[3:0] = v[11:8];
    end
    if (!only_unknown || !fat_known[p]) send_write(p, b0);
    if (!only_unknown || !fat_known[p + 1]) send_write(p + 1, b1);
  endtask

  // Writes any table byte that the coming walk would read before it has been written.
  task automatic fill_chain(input logic [11:0] head, input logic [15:0] size);
    logic [11:0] c;
    logic [11:0] nxt;
    int          lim;
    int          n;
    int          p;
    if (head == END_MARK) return;
    lim = cluster_limit(size);
    c = head;
    n = 1;
    while (n < MAX_CHAIN && n != lim) begin
      p = int'(c) * 3 / 2;
      if (!fat_known[p] || !fat_known[p + 1])
        set_entry(c, ($urandom_range(99) < 30) ? END_MARK : 12'($urandom), 1'b1);
      nxt = fat_entry(c);
      if (nxt == END_MARK) break;
      c = nxt;
      n++;
    end
  endtask

  task automatic run_episode();
    logic [11:0] chain [20];
    logic [11:0] head;
    logic [15:0] size;
    int          len;
    int          pick;
    int          i;
    pick = $urandom_range(99);
    if (pick < 55) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (i = 0; i < len; i++) chain[i] = 12'($urandom_range(0, 4094));
      for (i = 0; i < len - 1; i++) set_entry(chain[i], chain[i + 1], 1'b0);
      pick = $urandom_range(99);
      if (pick < 60) set_entry(chain[len - 1], END_MARK, 1'b0);
      else if (pick < 85) set_entry(chain[len - 1], chain[$urandom_range(0, len - 1)], 1'b0);
      pick = $urandom_range(99);
      if (pick < 35) size = 16'd0;
      else if (pick < 75) size = 16'($urandom_range(1, len * CLUSTER_BYTES + 300));
      else if (pick < 85) size = 16'd32768;
      else size = 16'($urandom_range(0, 32768));
      fill_chain(chain[0], size);
      send_walk(chain[0], size, $urandom);
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 3)) send_write($urandom_range(0, FAT_BYTES - 1), 8'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) head = END_MARK;
      else if (pick < 20) head = 12'($urandom_range(0, 1));
      else head = 12'($urandom_range(0, 4094));
      pick = $urandom_range(99);
      if (pick < 20) size = 16'd0;
      else if (pick < 70) size = 16'($urandom_range(1, 2048));
      else size = 16'($urandom_range(0, 32768));
      fill_chain(head, size);
      send_walk(head, size, $urandom);
    end
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (descriptors_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_data_base(input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we        = 1'b0;
    data_base_now = value;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] base,
                           input bit hold_out, input bit pause_in);
    int  first;
    bit  pressed;
    wait_drained();
    write_data_base(base);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_sent;
    pressed = 1'b0;
    while (items_sent - first < ITEMS_PER_PHASE) begin
      if (!pressed && items_sent - first > ITEMS_PER_PHASE / 2) begin
        pressed = 1'b1;
        if (hold_out) hold_req = 1'b1;
        if (pause_in) wait_drained();
      end
      run_episode();
    end
  endtask

  // Receiver side: random stalls, plus one long hold when asked for.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      out_if.ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    descriptor_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      descriptors_seen++;
      if (out_if.status == STATUS_ABORT) aborts_seen++;
      if (out_if.status == STATUS_EMPTY) empties_seen++;
      if (descriptors_due.size() == 0) begin
        $error("descriptor for cluster %0h arrived with none expected", out_if.cluster);
        mismatches++;
      end else begin
        want = descriptors_due.pop_front();
        if (out_if.source_address !== want.source_address) begin
          $error("source_address: expected %h, got %h", want.source_address,
                 out_if.source_address);
          mismatches++;
        end
        if (out_if.dest_address !== want.dest_address) begin
          $error("dest_address: expected %h, got %h", want.dest_address, out_if.dest_address);
          mismatches++;
        end
        if (out_if.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, out_if.byte_count);
          mismatches++;
        end
        if (out_if.cluster !== want.cluster) begin
          $error("cluster: expected %h, got %h", want.cluster, out_if.cluster);
          mismatches++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_if.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 32'd0;
    in_if.valid         = 1'b0;
    in_if.command       = CMD_WRITE;
    in_if.fat_index     = 13'd0;
    in_if.fat_byte      = 8'd0;
    in_if.first_cluster = 12'd0;
    in_if.file_size     = 16'd0;
    in_if.dest_base     = 32'd0;
    data_base_now       = 32'd0;
    hold_req            = 1'b0;
    send_idle_pct       = 31;
    recv_idle_pct       = 60;
    mismatches          = 0;
    items_sent          = 0;
    walks_sent          = 0;
    writes_sent         = 0;
    descriptors_seen    = 0;
    aborts_seen         = 0;
    empties_seen        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED[i]) send_cmd(DIRECTED[i].item, DIRECTED[i].fixed, DIRECTED[i].want);

    run_phase(31, 60, 32'hFFFF_FFFF, 1'b0, 1'b0);
    run_phase(60, 31, $urandom, 1'b0, 1'b1);
    run_phase(0, 0, 32'd0, 1'b1, 1'b0);

    in_if.valid = 1'b0;
    while (descriptors_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d table writes and %0d chain walks over three data base settings.",
             writes_sent, walks_sent);
    $display("Checked %0d descriptors, %0d of them overlong aborts and %0d empty chains.",
             descriptors_seen, aborts_seen, empties_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
